/* src/dbd_pkg.sv */
`timescale 1ns / 1ps

package dbd_pkg;

  localparam int MAX_FEATURES_DEF = 128;
  localparam int MAX_BOXES_DEF    = 16384;

  localparam int MIN_FEATURES  = 6;
  localparam int OBJ_POS       = 4;
  localparam int FIRST_CLASS   = 5;

  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEATURE_COUNT   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X         = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y         = 8'd3;

  localparam logic [16:0] RST_SCORE_THRESHOLD = 17'd32768;
  localparam logic [7:0]  RST_FEATURE_COUNT   = 8'd84;
  localparam logic [23:0] RST_SCALE_X         = 24'd65536;
  localparam logic [23:0] RST_SCALE_Y         = 24'd65536;

  // one finished box, handed from the accumulator to the multiplier stage
  typedef struct packed {
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [31:0] w;
    logic signed [31:0] h;
    logic signed [31:0] obj;
    logic signed [31:0] best;
    logic [6:0]         cls;
    logic [13:0]        idx;
  } box_t;

  // registered products of one box
  typedef struct packed {
    logic signed [63:0] prod;
    logic signed [58:0] px;
    logic signed [58:0] py;
    logic signed [56:0] pw;
    logic signed [56:0] ph;
    logic [6:0]         cls;
    logic [13:0]        idx;
  } prod_t;

endpackage

/* src/dbd_accum.sv */
`timescale 1ns / 1ps

module dbd_accum #(
  parameter int MAX_FEATURES = dbd_pkg::MAX_FEATURES_DEF,
  parameter int MAX_BOXES    = dbd_pkg::MAX_BOXES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] feature_value,
  input  logic [7:0]         feature_count,
  output logic               box_valid,
  input  logic               box_ready,
  output dbd_pkg::box_t      box
);
  import dbd_pkg::*;

  localparam int PW = $clog2(MAX_FEATURES);
  localparam int LW = (PW + 1 > 8) ? PW + 1 : 8;
  localparam int BW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

  logic [PW-1:0]      pos;
  logic [BW-1:0]      box_cnt;
  logic signed [31:0] geo [4];
  logic signed [31:0] obj;
  logic signed [31:0] best;
  logic [6:0]         cls;

  logic [LW-1:0]      fc_ext;
  logic [LW-1:0]      lim;
  logic               last;
  logic               accept;
  logic signed [31:0] obj_next;
  logic signed [31:0] best_next;
  logic [6:0]         cls_next;
  logic signed [31:0] best_base;
  logic [6:0]         cls_base;

  assign in_ready = !box_valid || box_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    fc_ext = LW'(feature_count);
    if (fc_ext < LW'(MIN_FEATURES)) begin
      lim = LW'(MIN_FEATURES);
    end else if (fc_ext > LW'(MAX_FEATURES)) begin
      lim = LW'(MAX_FEATURES);
    end else begin
      lim = fc_ext;
    end
    last = LW'(pos) >= (lim - LW'(1));
  end

  always_comb begin
    best_base = (pos == '0) ? 32'sd0 : best;
    cls_base  = (pos == '0) ? 7'd0 : cls;
    obj_next  = (pos == PW'(OBJ_POS)) ? feature_value : obj;
    best_next = best_base;
    cls_next  = cls_base;
    if (pos >= PW'(FIRST_CLASS) && feature_value > best_base) begin
      best_next = feature_value;
      cls_next  = 7'(pos - PW'(FIRST_CLASS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      box_cnt   <= '0;
      obj       <= '0;
      best      <= '0;
      cls       <= '0;
      box_valid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        geo[i] <= '0;
      end
    end else begin
      if (box_ready) begin
        box_valid <= 1'b0;
      end
      if (accept) begin
        if (pos < PW'(OBJ_POS)) begin
          geo[pos[1:0]] <= feature_value;
        end
        obj  <= obj_next;
        best <= best_next;
        cls  <= cls_next;
        if (last) begin
          pos       <= '0;
          box_cnt   <= (box_cnt == BW'(MAX_BOXES - 1)) ? '0 : box_cnt + BW'(1);
          box_valid <= 1'b1;
        end else begin
          pos <= pos + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last) begin
      box.dx   <= {geo[0][31], geo[0], 1'b0} - {{2{geo[2][31]}}, geo[2]};
      box.dy   <= {geo[1][31], geo[1], 1'b0} - {{2{geo[3][31]}}, geo[3]};
      box.w    <= geo[2];
      box.h    <= geo[3];
      box.obj  <= obj_next;
      box.best <= best_next;
      box.cls  <= cls_next;
      box.idx  <= 14'(box_cnt);
    end
  end

endmodule

/* src/dbd_mult.sv */
`timescale 1ns / 1ps

module dbd_mult (
  input  logic           clk,
  input  logic           rst,
  input  logic           box_valid,
  output logic           box_ready,
  input  dbd_pkg::box_t  box,
  input  logic [23:0]    scale_x,
  input  logic [23:0]    scale_y,
  output logic           prod_valid,
  input  logic           prod_ready,
  output dbd_pkg::prod_t prod
);
  import dbd_pkg::*;

  logic signed [24:0] sx;
  logic signed [24:0] sy;

  assign sx        = $signed({1'b0, scale_x});
  assign sy        = $signed({1'b0, scale_y});
  assign box_ready = !prod_valid || prod_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (box_ready) begin
      prod_valid <= box_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (box_ready && box_valid) begin
      prod.prod <= box.obj * box.best;
      prod.px   <= box.dx * sx;
      prod.py   <= box.dy * sy;
      prod.pw   <= box.w * sx;
      prod.ph   <= box.h * sy;
      prod.cls  <= box.cls;
      prod.idx  <= box.idx;
    end
  end

endmodule

/* src/dbd_out.sv */
`timescale 1ns / 1ps

module dbd_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               prod_valid,
  output logic               prod_ready,
  input  dbd_pkg::prod_t     prod,
  input  logic [16:0]        score_threshold,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] box_left,
  output logic signed [15:0] box_top,
  output logic signed [15:0] box_width,
  output logic signed [15:0] box_height,
  output logic [30:0]        score,
  output logic [6:0]         class_index,
  output logic [13:0]        box_index
);
  import dbd_pkg::*;

  function automatic logic signed [15:0] trunc_sat16(input logic signed [63:0] p,
                                                     input int sh);
    logic signed [63:0] bias;
    logic signed [63:0] q;
    bias = p[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
    q    = (p + bias) >>> sh;
    if (q > 64'sd32767) begin
      trunc_sat16 = 16'sh7FFF;
    end else if (q < -64'sd32768) begin
      trunc_sat16 = 16'sh8000;
    end else begin
      trunc_sat16 = q[15:0];
    end
  endfunction

  logic        keep;
  logic [30:0] score_sat;

  assign prod_ready = !out_valid || out_ready;

  always_comb begin
    keep      = !prod.prod[63] && (prod.prod[63:16] > {31'd0, score_threshold});
    score_sat = (|prod.prod[62:47]) ? 31'h7FFF_FFFF : prod.prod[46:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (prod_ready) begin
      out_valid <= prod_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && prod_valid) begin
      box_left    <= trunc_sat16(64'(prod.px), 33);
      box_top     <= trunc_sat16(64'(prod.py), 33);
      box_width   <= trunc_sat16(64'(prod.pw), 32);
      box_height  <= trunc_sat16(64'(prod.ph), 32);
      score       <= score_sat;
      class_index <= prod.cls;
      box_index   <= prod.idx;
    end
  end

endmodule

/* src/detection_box_decoder_core.sv */
`timescale 1ns / 1ps

// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+--------------------------------------
// in       | in        | in_valid / in_ready  | feature_value
// out      | out       | out_valid / out_ready| box_left, box_top, box_width,
//          |           |                      | box_height, score, class_index, box_index
// cfg      | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One feature beat is taken every cycle while in_ready is high; the running argmax is one compare per beat.
// A box's last feature passes the snapshot, multiply and round registers in turn; out_valid then
// rises for that box only if its score is above score_threshold.
// Reset clears position, box counter, argmax and all valid flags; cfg is always ready.
// A stalled out beat backs the three-stage pipeline up; in_ready drops only when all
// three stages hold a box.

module detection_box_decoder_core #(
  parameter int MAX_FEATURES = dbd_pkg::MAX_FEATURES_DEF,
  parameter int MAX_BOXES    = dbd_pkg::MAX_BOXES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [31:0]            feature_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [15:0]            box_left,
  output logic signed [15:0]            box_top,
  output logic signed [15:0]            box_width,
  output logic signed [15:0]            box_height,
  output logic [30:0]                   score,
  output logic [6:0]                    class_index,
  output logic [13:0]                   box_index,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dbd_pkg::CFG_DAT_W-1:0] cfg_data
);
  import dbd_pkg::*;

  logic [16:0] score_threshold;
  logic [7:0]  feature_count;
  logic [23:0] scale_x;
  logic [23:0] scale_y;

  logic        box_valid;
  logic        box_ready;
  box_t        box;
  logic        prod_valid;
  logic        prod_ready;
  prod_t       prod;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      score_threshold <= RST_SCORE_THRESHOLD;
      feature_count   <= RST_FEATURE_COUNT;
      scale_x         <= RST_SCALE_X;
      scale_y         <= RST_SCALE_Y;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCORE_THRESHOLD: score_threshold <= cfg_data[16:0];
        REG_FEATURE_COUNT:   feature_count   <= cfg_data[7:0];
        REG_SCALE_X:         scale_x         <= cfg_data[23:0];
        REG_SCALE_Y:         scale_y         <= cfg_data[23:0];
        default: begin
        end
      endcase
    end
  end

  dbd_accum #(
    .MAX_FEATURES(MAX_FEATURES),
    .MAX_BOXES   (MAX_BOXES)
  ) u_accum (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .feature_value(feature_value),
    .feature_count(feature_count),
    .box_valid    (box_valid),
    .box_ready    (box_ready),
    .box          (box)
  );

  dbd_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .box_valid (box_valid),
    .box_ready (box_ready),
    .box       (box),
    .scale_x   (scale_x),
    .scale_y   (scale_y),
    .prod_valid(prod_valid),
    .prod_ready(prod_ready),
    .prod      (prod)
  );

  dbd_out u_out (
    .clk            (clk),
    .rst            (rst),
    .prod_valid     (prod_valid),
    .prod_ready     (prod_ready),
    .prod           (prod),
    .score_threshold(score_threshold),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .box_left       (box_left),
    .box_top        (box_top),
    .box_width      (box_width),
    .box_height     (box_height),
    .score          (score),
    .class_index    (class_index),
    .box_index      (box_index)
  );

`ifndef SYNTHESIS
  a_score_above_thr: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (score > {14'd0, score_threshold}))
    else $error("result score not above threshold");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready && box_valid && prod_valid))
    else $error("input stalled with free pipeline stage");

  a_result_has_product: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(prod_valid))
    else $error("result raised without a product beat");
`endif

endmodule
